### design/sha1_byte_stream_hasher_top_assert.svh
// Assertion macros used by the hasher controller.
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// Checks that an antecedent implies a consequent on the same edge.
`define SH1_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent on the next edge.
`define SH1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types, constants and round functions for the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD80,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      put_byte;
        byte_sel_t byte_sel;
        logic      count_byte;
        logic      start_block;
        logic      do_round;
        logic      finish_block;
        logic      restart;
        logic      shift_out;
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;
        logic [5:0] fill;
        logic       last_round;
    } dp_stat_t;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam int unsigned DIGEST_WORDS = 5;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
                k = 32'h5A827999;
            else if (r < 7'd40)
                k = 32'h6ED9EBA1;
            else if (r < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
                f = d ^ (b & (c ^ d));
            else if (r >= 7'd40 && r < 7'd60)
                f = (b & c) | (d & (b | c));
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

### design/sha1_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Message schedule window that also buffers the block, round registers and
// chaining words.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  sha1_pkg::dp_cmd_t cmd,
    output sha1_pkg::dp_stat_t stat,
    output logic [31:0]       head_word
);

    logic [5:0]   fill_reg;
    logic         full_reg;
    logic [60:0]  count_reg;
    logic [31:0]  h_reg [5];
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   round_reg;
    logic [7:0]   byte_val;
    logic [63:0]  bit_len;
    logic [31:0]  w_x;
    logic [31:0]  t_val;

    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            sha1_pkg::BYTE_DATA:  byte_val = data_byte;
            sha1_pkg::BYTE_PAD80: byte_val = 8'h80;
            sha1_pkg::BYTE_ZERO:  byte_val = 8'h00;
            sha1_pkg::BYTE_LEN:   byte_val = bit_len[{~fill_reg[2:0], 3'b111} -: 8];
            default:              byte_val = 8'h00;
        endcase
    end

    assign w_x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    assign t_val = {a_reg[26:0], a_reg[31:27]}
                 + sha1_pkg::round_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + w_reg[0] + sha1_pkg::round_k(round_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
        begin
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
        else if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= {w_x[30:0], w_x[31]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            full_reg  <= 1'b0;
            count_reg <= '0;
            round_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= sha1_pkg::H_INIT[i];
            end
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end
        else
        begin
            if (cmd.put_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
                full_reg <= (fill_reg == 6'd63);
            end
            if (cmd.count_byte)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.start_block)
            begin
                full_reg  <= 1'b0;
                round_reg <= '0;
                a_reg     <= h_reg[0];
                b_reg     <= h_reg[1];
                c_reg     <= h_reg[2];
                d_reg     <= h_reg[3];
                e_reg     <= h_reg[4];
            end
            else if (cmd.do_round)
            begin
                round_reg <= round_reg + 7'd1;
                a_reg     <= t_val;
                b_reg     <= a_reg;
                c_reg     <= {b_reg[1:0], b_reg[31:2]};
                d_reg     <= c_reg;
                e_reg     <= d_reg;
            end
            if (cmd.finish_block)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    h_reg[i] <= h_reg[i + 1];
                end
                h_reg[4] <= h_reg[0];
            end
            if (cmd.restart)
            begin
                fill_reg  <= '0;
                count_reg <= '0;
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= sha1_pkg::H_INIT[i];
                end
            end
        end
    end

    assign stat.block_full = full_reg;
    assign stat.fill       = fill_reg;
    assign stat.last_round = (round_reg == 7'd79);
    assign head_word       = h_reg[0];

endmodule

### design/sha1_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
`include "sha1_byte_stream_hasher_top_assert.svh"

module sha1_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               has_byte,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         word_index,
    output sha1_pkg::dp_cmd_t  cmd,
    input  sha1_pkg::dp_stat_t stat
);

    sha1_pkg::state_t state_reg, state_next;
    logic             last_reg, last_next;
    logic             pad_reg, pad_next;
    logic             len_reg, len_next;
    logic [2:0]       idx_reg, idx_next;
    logic             in_fire;

    assign in_fire    = in_valid && !in_stall;
    assign in_stall   = (state_reg != sha1_pkg::ST_IDLE) || stat.block_full;
    assign out_valid  = (state_reg == sha1_pkg::ST_EMIT);
    assign word_index = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::ST_IDLE;
            last_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            len_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.byte_sel = sha1_pkg::BYTE_DATA;
        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (stat.block_full)
                begin
                    cmd.start_block = 1'b1;
                    state_next      = sha1_pkg::ST_ROUND;
                end
                else if (in_fire)
                begin
                    cmd.put_byte   = has_byte;
                    cmd.count_byte = has_byte;
                    last_next      = is_last;
                    pad_next       = 1'b0;
                    len_next       = 1'b0;
                    if (has_byte && stat.fill == 6'd63)
                        state_next = sha1_pkg::ST_IDLE;
                    else if (is_last)
                        state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (stat.last_round)
                begin
                    state_next = sha1_pkg::ST_FINISH;
                end
            end
            sha1_pkg::ST_FINISH:
            begin
                cmd.finish_block = 1'b1;
                if (!last_reg)
                begin
                    state_next = sha1_pkg::ST_IDLE;
                end
                else if (len_reg)
                begin
                    idx_next   = '0;
                    state_next = sha1_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_PAD:
            begin
                if (stat.block_full)
                begin
                    cmd.start_block = 1'b1;
                    state_next      = sha1_pkg::ST_ROUND;
                end
                else if (!pad_reg)
                begin
                    cmd.put_byte = 1'b1;
                    cmd.byte_sel = sha1_pkg::BYTE_PAD80;
                    pad_next     = 1'b1;
                end
                else if (!len_reg)
                begin
                    cmd.put_byte = 1'b1;
                    if (stat.fill == sha1_pkg::LEN_OFFSET)
                    begin
                        cmd.byte_sel = sha1_pkg::BYTE_LEN;
                        len_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.byte_sel = sha1_pkg::BYTE_ZERO;
                    end
                end
                else
                begin
                    cmd.put_byte = 1'b1;
                    cmd.byte_sel = sha1_pkg::BYTE_LEN;
                end
            end
            sha1_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'(sha1_pkg::DIGEST_WORDS - 1))
                    begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        last_next   = 1'b0;
                        pad_next    = 1'b0;
                        len_next    = 1'b0;
                        state_next  = sha1_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    `SH1_ASSERT_IMPL(a_no_take_busy, in_stall, !in_fire, "input taken while busy")
    `SH1_ASSERT_NEXT(a_round_to_emit, out_valid && out_stall, out_valid, "digest dropped")
    `SH1_ASSERT_IMPL(a_index_range, out_valid, idx_reg <= 3'd4, "word index out of range")

endmodule

### design/sha1_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a byte stream with SHA-1 and returns the digest as five words.
// ----------------------------------------------------------------------------
// The input takes one byte a cycle while idle; every 64th byte stalls the input
// while the block is compressed: the round registers are loaded, the rounds are
// run and the result is added into the chaining words. An item with is_last pads
// the block one byte a cycle, held while a full block is compressed; in all it
// runs one or two more compressions and then offers five digest transactions;
// the input stays stalled until the fifth one is taken.
module sha1_byte_stream_hasher_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha1_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sha1_pkg::out_item_t out_data
);

    sha1_pkg::dp_cmd_t  cmd;
    sha1_pkg::dp_stat_t stat;
    logic [31:0]        head_word;
    logic [2:0]         idx;

    sha1_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .has_byte   (in_data.has_byte),
        .is_last    (in_data.is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (idx),
        .cmd        (cmd),
        .stat       (stat)
    );

    sha1_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_data.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .head_word (head_word)
    );

    assign out_data.digest_word = head_word;
    assign out_data.word_index  = idx;
    assign out_data.last_word   = (idx == 3'(sha1_pkg::DIGEST_WORDS - 1));

endmodule

### test/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels of the hasher, hashes the accepted bytes on its own
// and compares every digest transaction with the oldest expected word.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  sha1_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  sha1_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending_words
);

    logic [31:0]         hash_words [5];
    logic [7:0]          block_bytes [64];
    int                  fill_level;
    logic [60:0]         byte_total;
    int                  errors = 0;
    sha1_pkg::out_item_t expected_words [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (d & (b | c));
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endtask

    task automatic absorb(input logic [7:0] v);
        block_bytes[fill_level] = v;
        fill_level++;
        if (fill_level == 64)
        begin
            compress();
            fill_level = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 5; i++)
            hash_words[i] = sha1_pkg::H_INIT[i];
        fill_level = 0;
        byte_total = '0;
    endtask

    task automatic take_item(input sha1_pkg::in_item_t item);
        logic [63:0]         bit_length;
        sha1_pkg::out_item_t word;
        if (item.has_byte)
        begin
            absorb(item.data_byte);
            byte_total = byte_total + 61'd1;
        end
        if (item.is_last)
        begin
            bit_length = {byte_total, 3'b000};
            absorb(8'h80);
            while (fill_level != 56)
                absorb(8'h00);
            for (int i = 0; i < 8; i++)
                absorb(bit_length[63 - 8*i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                word.digest_word = hash_words[i];
                word.word_index = 3'(i);
                word.last_word = (i == 4);
                expected_words.push_back(word);
            end
            restart_message();
        end
    endtask

    assign fail_count = errors;
    assign pending_words = expected_words.size();

    always @(posedge clk)
    begin
        sha1_pkg::out_item_t want;
        if (!rst_n)
        begin
            restart_message();
        end
        else
        begin
            if (in_valid && !in_stall)
                take_item(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected digest transaction %h", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.digest_word !== want.digest_word)
                    begin
                        $error("digest_word expected %h actual %h",
                               want.digest_word, out_data.digest_word);
                        errors++;
                    end
                    if (out_data.word_index !== want.word_index)
                    begin
                        $error("word_index expected %0d actual %0d",
                               want.word_index, out_data.word_index);
                        errors++;
                    end
                    if (out_data.last_word !== want.last_word)
                    begin
                        $error("last_word expected %0d actual %0d",
                               want.last_word, out_data.last_word);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hasher testbench
// Sends directed and random messages through the hasher with random gaps and
// back-pressure, including one long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sha1_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b1;
    sha1_pkg::out_item_t out_data;
    int                  fail_count;
    int                  pending_words;
    int                  cycle_count = 0;
    int                  hold_off = 0;
    int                  items_sent = 0;

    always #6 clk = ~clk;

    sha1_byte_stream_hasher_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    sha1_digest_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data), .fail_count(fail_count), .pending_words(pending_words)
    );

    task automatic send_item(input logic [7:0] v, input logic has, input logic fin,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: v, has_byte: has, is_last: fin};
        items_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_message(input int len, input bit last_has, input bit no_gap);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, no_gap);
            send_item(8'($urandom), 1'b1, 1'b0, no_gap);
        end
        send_item(8'($urandom), last_has, 1'b1, no_gap);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Output back-pressure: random stalls, no stalls in some stretches, and a
    // long hold-off while the sender keeps offering.
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0 && !held)
            begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
                held = 1'b1;
            end
            n = $urandom_range(0, 15);
            out_stall <= ($urandom_range(0, 3) != 0) && n > 0;
            repeat (n > 0 ? n : 1) @(posedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Empty message, byte carried on the ending item, edge byte values.
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0, 1'b1);
        send_item(8'h5A, 1'b1, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        send_item(8'h12, 1'b0, 1'b0, 1'b1);
        send_item(8'h34, 1'b0, 1'b1, 1'b1);
        // Long hold-off on the output while messages keep coming.
        hold_off = 600;
        for (int i = 0; i < 3; i++)
            send_message(2, 1'b1, 1'b1);
        // A 56-byte message pushes the length into one more block.
        send_message(55, 1'b1, 1'b0);
        while (items_sent < 120)
        begin
            send_message($urandom_range(0, 12), 1'($urandom), 1'b0);
        end
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
